/* hdl/bdt_pkg.sv */
// Shared types and constants for the byte order mark detector / UTF-16 transcoder.
// Used by every module of the block; depends on nothing.
package bdt_pkg;

   localparam logic [2:0] ENC_UTF8   = 3'd0;
   localparam logic [2:0] ENC_U16LE  = 3'd1;
   localparam logic [2:0] ENC_U16BE  = 3'd2;
   localparam logic [2:0] ENC_U32LE  = 3'd3;
   localparam logic [2:0] ENC_U32BE  = 3'd4;

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_UTF8     = 3'd1;
   localparam logic [2:0] ERR_ODD16    = 3'd2;
   localparam logic [2:0] ERR_PAIR     = 3'd3;
   localparam logic [2:0] ERR_LONE_LOW = 3'd4;
   localparam logic [2:0] ERR_COUNT32  = 3'd5;
   localparam logic [2:0] ERR_CODEPT   = 3'd6;

   localparam int QDEPTH = 4;
   localparam int QPTRW  = $clog2(QDEPTH);

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       end_of_file;
      logic [2:0] encoding;
   } op_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        unit_valid;
      logic [2:0]  detected_encoding;
      logic [2:0]  error_code;
      logic        last_of_file;
   } rsp_type;

   typedef enum logic [1:0] {
      FS_DETECT,
      FS_REPLAY,
      FS_PASS
   } front_state_type;

endpackage

/* hdl/bdt_op_queue.sv */
// Short word queue between the front end and the decoder.
// Depends on bdt_pkg.
module bdt_op_queue import bdt_pkg::*; (
   input  logic   clock,
   input  logic   reset,
   input  logic   wr_en,
   input  op_type wr_word,
   output logic   q_full,
   input  logic   rd_en,
   output op_type rd_word,
   output logic   q_empty
);

   op_type              mem_ff [QDEPTH];
   logic [QPTRW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QPTRW:0]      count_ff, count_in;

   assign q_full  = (count_ff == (QPTRW+1)'(QDEPTH));
   assign q_empty = (count_ff == '0);
   assign rd_word = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      if (rd_en && !wr_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_word;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/bdt_rsp_queue.sv */
// Result queue at the output; the oldest word is shown while not empty.
// Depends on bdt_pkg.
module bdt_rsp_queue import bdt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    wr_en,
   input  rsp_type wr_word,
   output logic    q_full,
   input  logic    rd_en,
   output rsp_type rd_word,
   output logic    q_empty
);

   rsp_type             mem_ff [QDEPTH];
   logic [QPTRW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [QPTRW:0]      count_ff, count_in;

   assign q_full  = (count_ff == (QPTRW+1)'(QDEPTH));
   assign q_empty = (count_ff == '0);
   assign rd_word = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (wr_en && !rd_en) count_in = count_ff + 1'b1;
      if (rd_en && !wr_en) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_word;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_in;
      end
   end

endmodule

/* hdl/bdt_front.sv */
// Front end: holds leading bytes, detects the byte order mark, replays
// held bytes and passes later bytes to the op queue. Depends on bdt_pkg.
module bdt_front import bdt_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic [7:0] in_byte,
   input  logic       in_byte_valid,
   input  logic       in_eof,
   input  logic       in_push,
   output logic       in_full,
   output logic       op_push,
   output op_type     op_word,
   input  logic       op_full
);

   front_state_type state_ff, state_in;
   logic [7:0] look_ff [4];
   logic [7:0] look_in [4];
   logic [2:0] cnt_ff, cnt_in;
   logic [2:0] enc_ff, enc_in;
   logic [1:0] idx_ff, idx_in;
   logic       eof_ff, eof_in;
   logic       accept;
   logic [2:0] dec_enc;
   logic [2:0] mark_len;
   logic       rep_last;

   assign in_full = (state_ff == FS_REPLAY) || op_full;
   assign accept  = in_push && !in_full;
   assign rep_last = ({1'b0, idx_ff} == (cnt_ff - 3'd1));

   always_comb begin
      state_in = state_ff;
      look_in  = look_ff;
      cnt_in   = cnt_ff;
      enc_in   = enc_ff;
      idx_in   = idx_ff;
      eof_in   = eof_ff;
      op_push  = 1'b0;
      op_word  = '{data_byte: in_byte, byte_valid: in_byte_valid,
                   end_of_file: in_eof, encoding: enc_ff};
      dec_enc  = ENC_UTF8;
      mark_len = 3'd0;
      case (state_ff)
         FS_DETECT: begin
            if (accept) begin
               if (in_byte_valid) begin
                  look_in[cnt_ff[1:0]] = in_byte;
                  cnt_in = cnt_ff + 3'd1;
               end
               if (cnt_in == 3'd4 || in_eof) begin
                  if (cnt_in >= 3'd3 && look_in[0] == 8'hEF && look_in[1] == 8'hBB &&
                      look_in[2] == 8'hBF) begin
                     dec_enc = ENC_UTF8;  mark_len = 3'd3;
                  end else if (cnt_in == 3'd4 && look_in[0] == 8'hFF &&
                               look_in[1] == 8'hFE && look_in[2] == 8'h00 &&
                               look_in[3] == 8'h00) begin
                     dec_enc = ENC_U32LE; mark_len = 3'd4;
                  end else if (cnt_in == 3'd4 && look_in[0] == 8'h00 &&
                               look_in[1] == 8'h00 && look_in[2] == 8'hFE &&
                               look_in[3] == 8'hFF) begin
                     dec_enc = ENC_U32BE; mark_len = 3'd4;
                  end else if (cnt_in >= 3'd2 && look_in[0] == 8'hFF &&
                               look_in[1] == 8'hFE) begin
                     dec_enc = ENC_U16LE; mark_len = 3'd2;
                  end else if (cnt_in >= 3'd2 && look_in[0] == 8'hFE &&
                               look_in[1] == 8'hFF) begin
                     dec_enc = ENC_U16BE; mark_len = 3'd2;
                  end
                  enc_in = dec_enc;
                  if (mark_len < cnt_in) begin
                     state_in = FS_REPLAY;
                     idx_in   = mark_len[1:0];
                     eof_in   = in_eof;
                  end else if (in_eof) begin
                     op_push  = 1'b1;
                     op_word  = '{data_byte: 8'h00, byte_valid: 1'b0,
                                  end_of_file: 1'b1, encoding: dec_enc};
                     cnt_in   = 3'd0;
                     enc_in   = ENC_UTF8;
                  end else begin
                     state_in = FS_PASS;
                  end
               end
            end
         end
         FS_REPLAY: begin
            if (!op_full) begin
               op_push = 1'b1;
               op_word = '{data_byte: look_ff[idx_ff], byte_valid: 1'b1,
                           end_of_file: eof_ff && rep_last, encoding: enc_ff};
               idx_in  = idx_ff + 2'd1;
               if (rep_last) begin
                  if (eof_ff) begin
                     state_in = FS_DETECT;
                     cnt_in   = 3'd0;
                     enc_in   = ENC_UTF8;
                  end else begin
                     state_in = FS_PASS;
                  end
               end
            end
         end
         FS_PASS: begin
            if (accept && (in_byte_valid || in_eof)) op_push = 1'b1;
            if (accept && in_eof) begin
               state_in = FS_DETECT;
               cnt_in   = 3'd0;
               enc_in   = ENC_UTF8;
            end
         end
         default: state_in = FS_DETECT;
      endcase
   end

   always_ff @(posedge clock) begin
      look_ff <= look_in;
      idx_ff  <= idx_in;
      eof_ff  <= eof_in;
      if (reset) begin
         state_ff <= FS_DETECT;
         cnt_ff   <= 3'd0;
         enc_ff   <= ENC_UTF8;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         enc_ff   <= enc_in;
      end
   end

endmodule

/* hdl/bdt_back.sv */
// Decoder: assembles code units per encoding, checks them and writes UTF-16
// result words, at most two per op word. Depends on bdt_pkg.
module bdt_back import bdt_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    op_valid,
   input  op_type  op_word,
   output logic    op_pop,
   output logic    rsp_push,
   output rsp_type rsp_word,
   input  logic    rsp_full
);

   logic [23:0] ub_ff, ub_in;
   logic [1:0]  ubc_ff, ubc_in;
   logic [15:0] pend_ff, pend_in;
   logic        pendv_ff, pendv_in;
   logic [20:0] acc_ff, acc_in;
   logic [1:0]  rem_ff, rem_in;
   logic [1:0]  len_ff, len_in;
   logic        drop_ff, drop_in;
   logic        second_ff, second_in;

   logic [2:0]  err;
   logic [1:0]  nu, nres;
   logic [15:0] u0, u1, u16;
   logic [20:0] cp;
   logic [20:0] vv;
   logic [31:0] cp32;
   logic        emit;
   logic [7:0]  b;
   logic [2:0]  enc;
   rsp_type     r0, r1;
   logic        step;

   assign b    = op_word.data_byte;
   assign enc  = op_word.encoding;
   assign step = op_valid && !rsp_full;

   always_comb begin
      ub_in = ub_ff;  ubc_in = ubc_ff;  pend_in = pend_ff;  pendv_in = pendv_ff;
      acc_in = acc_ff;  rem_in = rem_ff;  len_in = len_ff;
      err = ERR_NONE;  nu = 2'd0;  u0 = 16'h0;  u1 = 16'h0;
      cp = 21'h0;  emit = 1'b0;  u16 = 16'h0;  cp32 = 32'h0;
      if (op_word.byte_valid) begin
         case (enc)
            ENC_UTF8: begin
               if (rem_ff == 2'd0) begin
                  if (b < 8'h80) begin
                     u0 = {8'h00, b};  nu = 2'd1;
                  end else if (b inside {[8'hC2:8'hDF]}) begin
                     acc_in = {16'h0, b[4:0]};  rem_in = 2'd1;  len_in = 2'd1;
                  end else if (b inside {[8'hE0:8'hEF]}) begin
                     acc_in = {17'h0, b[3:0]};  rem_in = 2'd2;  len_in = 2'd2;
                  end else if (b inside {[8'hF0:8'hF4]}) begin
                     acc_in = {18'h0, b[2:0]};  rem_in = 2'd3;  len_in = 2'd3;
                  end else begin
                     err = ERR_UTF8;
                  end
               end else if (b[7:6] != 2'b10) begin
                  err = ERR_UTF8;
               end else if (rem_ff == len_ff &&
                            ((len_ff == 2'd2 && acc_ff == 21'h0 && b < 8'hA0) ||
                             (len_ff == 2'd2 && acc_ff == 21'hD && b > 8'h9F) ||
                             (len_ff == 2'd3 && acc_ff == 21'h0 && b < 8'h90) ||
                             (len_ff == 2'd3 && acc_ff == 21'h4 && b > 8'h8F))) begin
                  err = ERR_UTF8;
               end else begin
                  acc_in = {acc_ff[14:0], b[5:0]};
                  rem_in = rem_ff - 2'd1;
                  if (rem_in == 2'd0) begin
                     cp = acc_in;  emit = 1'b1;
                  end
               end
            end
            ENC_U16LE, ENC_U16BE: begin
               if (ubc_ff == 2'd0) begin
                  ub_in = {16'h0, b};  ubc_in = 2'd1;
               end else begin
                  u16 = (enc == ENC_U16LE) ? {b, ub_ff[7:0]} : {ub_ff[7:0], b};
                  ub_in = 24'h0;  ubc_in = 2'd0;
                  if (pendv_ff) begin
                     if (!(u16 inside {[16'hDC00:16'hDFFF]})) begin
                        err = ERR_PAIR;
                     end else begin
                        u0 = pend_ff;  u1 = u16;  nu = 2'd2;
                        pendv_in = 1'b0;  pend_in = 16'h0;
                     end
                  end else if (u16 inside {[16'hD800:16'hDBFF]}) begin
                     pend_in = u16;  pendv_in = 1'b1;
                  end else if (u16 inside {[16'hDC00:16'hDFFF]}) begin
                     err = ERR_LONE_LOW;
                  end else begin
                     u0 = u16;  nu = 2'd1;
                  end
               end
            end
            default: begin
               case (ubc_ff)
                  2'd0: begin ub_in = {16'h0, b};              ubc_in = 2'd1; end
                  2'd1: begin ub_in = {8'h0, b, ub_ff[7:0]};   ubc_in = 2'd2; end
                  2'd2: begin ub_in = {b, ub_ff[15:0]};        ubc_in = 2'd3; end
                  default: begin
                     cp32 = (enc == ENC_U32LE) ? {b, ub_ff} :
                            {ub_ff[7:0], ub_ff[15:8], ub_ff[23:16], b};
                     ub_in = 24'h0;  ubc_in = 2'd0;
                     if (cp32 > 32'h10FFFF || (cp32 inside {[32'hD800:32'hDFFF]})) begin
                        err = ERR_CODEPT;
                     end else begin
                        cp = cp32[20:0];  emit = 1'b1;
                     end
                  end
               endcase
            end
         endcase
      end
      vv = cp - 21'h10000;
      if (emit) begin
         if (cp < 21'h10000) begin
            u0 = cp[15:0];  nu = 2'd1;
         end else begin
            u0 = 16'hD800 + {6'h0, vv[19:10]};
            u1 = 16'hDC00 + {6'h0, vv[9:0]};
            nu = 2'd2;
         end
      end
      if (err == ERR_NONE && op_word.end_of_file) begin
         case (enc)
            ENC_UTF8: if (rem_in != 2'd0) err = ERR_UTF8;
            ENC_U16LE, ENC_U16BE: begin
               if (ubc_in != 2'd0) err = ERR_ODD16;
               else if (pendv_in) err = ERR_PAIR;
            end
            default: if (ubc_in != 2'd0) err = ERR_COUNT32;
         endcase
      end
   end

   always_comb begin
      r0 = '{code_unit: u0, unit_valid: 1'b1, detected_encoding: enc,
             error_code: ERR_NONE, last_of_file: 1'b0};
      r1 = '{code_unit: u1, unit_valid: 1'b1, detected_encoding: enc,
             error_code: ERR_NONE, last_of_file: op_word.end_of_file};
      nres = nu;
      if (err != ERR_NONE) begin
         r0 = '{code_unit: 16'h0, unit_valid: 1'b0, detected_encoding: enc,
                error_code: err, last_of_file: 1'b1};
         nres = 2'd1;
      end else if (op_word.end_of_file) begin
         if (nu == 2'd0) begin
            r0 = '{code_unit: 16'h0, unit_valid: 1'b0, detected_encoding: enc,
                   error_code: ERR_NONE, last_of_file: 1'b1};
            nres = 2'd1;
         end else if (nu == 2'd1) begin
            r0.last_of_file = 1'b1;
         end
      end
   end

   always_comb begin
      op_pop    = 1'b0;
      rsp_push  = 1'b0;
      rsp_word  = second_ff ? r1 : r0;
      second_in = second_ff;
      drop_in   = drop_ff;
      if (step) begin
         if (drop_ff) begin
            op_pop = 1'b1;
            if (op_word.end_of_file) drop_in = 1'b0;
         end else if (nres == 2'd2 && !second_ff) begin
            rsp_push  = 1'b1;
            second_in = 1'b1;
         end else begin
            rsp_push  = (nres != 2'd0);
            op_pop    = 1'b1;
            second_in = 1'b0;
            if (!op_word.end_of_file && err != ERR_NONE) drop_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ub_ff <= '0;  ubc_ff <= '0;  pend_ff <= '0;  pendv_ff <= 1'b0;
         acc_ff <= '0;  rem_ff <= '0;  len_ff <= '0;
         drop_ff <= 1'b0;  second_ff <= 1'b0;
      end else begin
         second_ff <= second_in;
         drop_ff   <= drop_in;
         if (op_pop) begin
            if (op_word.end_of_file) begin
               ub_ff <= '0;  ubc_ff <= '0;  pend_ff <= '0;  pendv_ff <= 1'b0;
               acc_ff <= '0;  rem_ff <= '0;  len_ff <= '0;
            end else if (!drop_ff) begin
               ub_ff <= ub_in;  ubc_ff <= ubc_in;  pend_ff <= pend_in;
               pendv_ff <= pendv_in;  acc_ff <= acc_in;  rem_ff <= rem_in;
               len_ff <= len_in;
            end
         end
      end
   end

endmodule

/* hdl/bom_detect_utf_to_utf16_transcoder.sv */
// Top level of the byte order mark detector and UTF-16 transcoder.
// Instantiates bdt_front, bdt_op_queue, bdt_back and bdt_rsp_queue; uses bdt_pkg.
//
// Input channel: one file byte per word (req_data_byte, req_byte_valid,
// req_end_of_file), taken when push is high and full is low. Result channel:
// one UTF-16 word per result, shown while empty is low, taken on pop.
// A byte is written to the op queue at the edge it is taken; the decoder reads it
// from there and writes its results to the result queue, which shows them.
// Bytes held for mark detection give results only once the mark is decided.
// Throughput is one byte per cycle while full is low. When the mark decision is
// made, held bytes (up to four) are replayed one per cycle with full high while
// the op queue has room; a byte that yields a surrogate pair holds the decoder
// until its two words are in the result queue, one per cycle while it has room.
// Bytes after an error are dropped up to the end of the file, with no result.
// Reset empties both queues and returns to mark detection at once.
// When the receiver stalls, the result queue fills, then the op queue, and
// full rises; nothing is lost.
module bom_detect_utf_to_utf16_transcoder import bdt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_end_of_file,
   input  logic        push,
   output logic        full,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_unit_valid,
   output logic [2:0]  rsp_detected_encoding,
   output logic [2:0]  rsp_error_code,
   output logic        rsp_last_of_file,
   output logic        empty,
   input  logic        pop
);

   logic    op_push, op_full, op_empty, op_pop;
   op_type  op_in_word, op_out_word;
   logic    rsp_push, rsp_full;
   rsp_type rsp_in_word, rsp_out_word;

   bdt_front u_front (
      .clock(clock), .reset(reset),
      .in_byte(req_data_byte), .in_byte_valid(req_byte_valid), .in_eof(req_end_of_file),
      .in_push(push), .in_full(full),
      .op_push(op_push), .op_word(op_in_word), .op_full(op_full)
   );

   bdt_op_queue u_op_queue (
      .clock(clock), .reset(reset),
      .wr_en(op_push), .wr_word(op_in_word), .q_full(op_full),
      .rd_en(op_pop), .rd_word(op_out_word), .q_empty(op_empty)
   );

   bdt_back u_back (
      .clock(clock), .reset(reset),
      .op_valid(!op_empty), .op_word(op_out_word), .op_pop(op_pop),
      .rsp_push(rsp_push), .rsp_word(rsp_in_word), .rsp_full(rsp_full)
   );

   bdt_rsp_queue u_rsp_queue (
      .clock(clock), .reset(reset),
      .wr_en(rsp_push), .wr_word(rsp_in_word), .q_full(rsp_full),
      .rd_en(pop && !empty), .rd_word(rsp_out_word), .q_empty(empty)
   );

   assign rsp_code_unit         = rsp_out_word.code_unit;
   assign rsp_unit_valid        = rsp_out_word.unit_valid;
   assign rsp_detected_encoding = rsp_out_word.detected_encoding;
   assign rsp_error_code        = rsp_out_word.error_code;
   assign rsp_last_of_file      = rsp_out_word.last_of_file;

endmodule

/* hdl/bdt_checker.sv */
// Port-level checks for the transcoder, bound to the top level.
// Depends on bdt_pkg and bom_detect_utf_to_utf16_transcoder's ports only.
module bdt_port_checker import bdt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        empty,
   input logic        pop,
   input logic        rsp_unit_valid,
   input logic [2:0]  rsp_error_code,
   input logic        rsp_last_of_file
);

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> empty) else $error("result queue not empty after reset");

   a_nounit_is_last: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_unit_valid) |-> rsp_last_of_file)
      else $error("non-unit word without last_of_file");

   a_err_no_unit: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_error_code != ERR_NONE) |-> !rsp_unit_valid)
      else $error("error word carries a unit");

   a_unit_no_err: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_unit_valid) |-> (rsp_error_code == ERR_NONE))
      else $error("unit word carries an error");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty) else $error("result dropped while stalled");

endmodule

bind bom_detect_utf_to_utf16_transcoder bdt_port_checker u_bdt_checker (
   .clock(clock), .reset(reset), .empty(empty), .pop(pop),
   .rsp_unit_valid(rsp_unit_valid), .rsp_error_code(rsp_error_code),
   .rsp_last_of_file(rsp_last_of_file)
);
